// ===== hdl/mfd_pkg.sv =====
package mfd_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = 2 * VW;
   localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
   localparam int CW = 17;
   localparam int FW = 23;
   localparam logic [CW-1:0] CELL_MAX = {CW{1'b1}};
   localparam logic [FW-1:0] FLOW_MAX = {FW{1'b1}};
   localparam logic [CW-1:0] PATH_CAP = CW'(32000);

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_SOLVE = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_CLEAR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_SEARCH_INIT,
      ST_NODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_MIN_ADR,
      ST_MIN_RD,
      ST_MIN_CHK,
      ST_UPD_ADR,
      ST_UPD_FRD,
      ST_UPD_FWR,
      ST_UPD_RRD,
      ST_UPD_RWR,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/max_flow_dfs_augmenting.sv =====
// Max-flow engine using repeated depth-first augmenting-path searches over a
// 64 x 64 capacity matrix held in block memories. A request transfer is taken
// when start is high and busy is low; busy stays high until the request is
// finished. After reset busy stays high while the capacity memory is cleared,
// one word per cycle, as it is for a clear request. An edge add reads the
// capacity word and writes back the saturated sum. A solve first copies the
// capacity memory to the residual memory, then each search step reads and
// checks one residual word, a step back pops to the previous vertex, and each
// augmenting path is walked once for its minimum and once to update the
// residuals; the total is data dependent. The flow total appears on
// rsp_max_flow for one cycle with rsp_valid, and the receiver cannot stall it.
module max_flow_dfs_augmenting (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_type,
   input  logic [5:0]                 req_from_vertex,
   input  logic [5:0]                 req_to_vertex,
   input  logic [14:0]                req_capacity,
   output logic                       rsp_valid,
   output logic [22:0]                rsp_max_flow
);
   import mfd_pkg::*;

   logic [CW-1:0] cap_mem [CELLS];
   logic [CW-1:0] res_mem [CELLS];
   logic [VW-1:0] stack_mem [MAX_VERTICES];
   logic          visited_ff [MAX_VERTICES];

   state_type state_ff, state_in;
   logic [AW-1:0] cap_addr, res_addr;
   logic          cap_we, res_we;
   logic [CW-1:0] cap_wd, res_wd, cap_rd_ff, res_rd_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in, u_ff, u_in;
   logic [14:0]   c_ff, c_in;
   logic [VW:0]   v_ff, v_in;
   logic [VW:0]   depth_ff, depth_in, len_ff, len_in, i_ff, i_in;
   logic [CW-1:0] amt_ff, amt_in;
   logic [FW-1:0] flow_ff, flow_in;
   logic [VW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic          vis_clr, vis_set;
   logic          st_we;
   logic [VW-1:0] st_idx, nx_idx;
   logic [VW-1:0] st_wd;
   logic [VW-1:0] st_ra0, st_ra1, st_rd0_ff, st_rd1_ff;
   logic [CW:0]   sum;
   logic [FW:0]   fsum;
   logic          accept;

   assign accept = start && !busy;
   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_addr] <= cap_wd;
      cap_rd_ff <= cap_mem[cap_addr];
      if (res_we) res_mem[res_addr] <= res_wd;
      res_rd_ff <= res_mem[res_addr];
      if (st_we) stack_mem[st_idx] <= st_wd;
      st_rd0_ff <= stack_mem[st_ra0];
      st_rd1_ff <= stack_mem[st_ra1];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
         if (reset || vis_clr) visited_ff[k] <= 1'b0;
         else if (vis_set && nx_idx == VW'(k)) visited_ff[k] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         flow_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         flow_ff <= flow_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      u_ff <= u_in; v_ff <= v_in; depth_ff <= depth_in; len_ff <= len_in;
      i_ff <= i_in; amt_ff <= amt_in; pa_ff <= pa_in; pb_ff <= pb_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff;
      u_in = u_ff; v_in = v_ff; depth_in = depth_ff; len_in = len_ff;
      i_in = i_ff; amt_in = amt_ff; flow_in = flow_ff; pa_in = pa_ff; pb_in = pb_ff;
      cap_addr = {a_ff, b_ff}; cap_we = 1'b0; cap_wd = '0;
      res_addr = {u_ff, v_ff[VW-1:0]}; res_we = 1'b0; res_wd = '0;
      vis_clr = 1'b0; vis_set = 1'b0;
      st_we = 1'b0; st_idx = depth_ff[VW-1:0]; st_wd = '0;
      st_ra0 = '0; st_ra1 = '0;
      nx_idx = u_ff;
      rsp_valid = 1'b0;
      sum = '0; fsum = '0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               a_in = req_from_vertex; b_in = req_to_vertex; c_in = req_capacity;
               case (req_type)
                  REQ_ADD: state_in = ST_ADD_RD;
                  REQ_SOLVE: begin
                     flow_in = '0;
                     state_in = (req_from_vertex == req_to_vertex) ? ST_DONE : ST_COPY_RD;
                  end
                  REQ_CLEAR: state_in = ST_CLEAR;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: begin
            sum = {1'b0, cap_rd_ff} + (CW+1)'(c_ff);
            cap_we = 1'b1;
            cap_wd = sum[CW] ? CELL_MAX : sum[CW-1:0];
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            cap_addr = cnt_ff[AW-1:0]; cap_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[AW-1:0] == {AW{1'b1}}) state_in = ST_IDLE;
         end
         ST_COPY_RD: begin
            cap_addr = cnt_ff[AW-1:0];
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            res_addr = cnt_ff[AW-1:0]; res_we = 1'b1; res_wd = cap_rd_ff;
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff[AW-1:0] == {AW{1'b1}}) ? ST_SEARCH_INIT : ST_COPY_RD;
         end
         ST_SEARCH_INIT: begin
            vis_clr = 1'b1;
            st_we = 1'b1; st_idx = '0; st_wd = a_ff;
            depth_in = '0;
            u_in = a_ff; v_in = '0;
            state_in = ST_NODE;
         end
         ST_NODE: begin
            // Mark and enter the vertex on top of the stack; its scan starts at v_ff.
            nx_idx = u_ff; vis_set = (v_ff == '0);
            if (u_ff == b_ff) begin
               len_in = depth_ff + 1'b1; i_in = '0; amt_in = PATH_CAP;
               state_in = ST_MIN_ADR;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (v_ff[VW]) begin
               if (depth_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  st_ra0 = VW'(depth_ff - 1'b1);
                  state_in = ST_POP;
               end
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!visited_ff[v_ff[VW-1:0]] && res_rd_ff != '0) begin
               st_we = 1'b1; st_idx = VW'(depth_ff + 1'b1); st_wd = v_ff[VW-1:0];
               depth_in = depth_ff + 1'b1;
               u_in = v_ff[VW-1:0]; v_in = '0;
               state_in = ST_NODE;
            end else begin
               v_in = v_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP: begin
            // The parent resumes its scan just past the vertex being left.
            depth_in = depth_ff - 1'b1;
            u_in = st_rd0_ff;
            v_in = {1'b0, u_ff} + 1'b1;
            state_in = ST_NODE;
         end
         ST_MIN_ADR: begin
            st_ra0 = i_ff[VW-1:0];
            st_ra1 = VW'(i_ff + 1'b1);
            state_in = ST_MIN_RD;
         end
         ST_MIN_RD: begin
            pa_in = st_rd0_ff;
            pb_in = st_rd1_ff;
            res_addr = {st_rd0_ff, st_rd1_ff};
            state_in = ST_MIN_CHK;
         end
         ST_MIN_CHK: begin
            if (res_rd_ff < amt_ff) amt_in = res_rd_ff;
            i_in = i_ff + 1'b1;
            if (i_ff + 2'd2 >= len_ff) begin
               i_in = '0;
               state_in = ST_UPD_ADR;
            end else begin
               state_in = ST_MIN_ADR;
            end
         end
         ST_UPD_ADR: begin
            st_ra0 = i_ff[VW-1:0];
            st_ra1 = VW'(i_ff + 1'b1);
            state_in = ST_UPD_FRD;
         end
         ST_UPD_FRD: begin
            pa_in = st_rd0_ff;
            pb_in = st_rd1_ff;
            res_addr = {st_rd0_ff, st_rd1_ff};
            state_in = ST_UPD_FWR;
         end
         ST_UPD_FWR: begin
            res_addr = {pa_ff, pb_ff}; res_we = 1'b1; res_wd = res_rd_ff - amt_ff;
            state_in = ST_UPD_RRD;
         end
         ST_UPD_RRD: begin
            res_addr = {pb_ff, pa_ff};
            state_in = ST_UPD_RWR;
         end
         ST_UPD_RWR: begin
            sum = {1'b0, res_rd_ff} + {1'b0, amt_ff};
            res_addr = {pb_ff, pa_ff}; res_we = 1'b1;
            res_wd = sum[CW] ? CELL_MAX : sum[CW-1:0];
            i_in = i_ff + 1'b1;
            if (i_ff + 2'd2 >= len_ff) begin
               fsum = {1'b0, flow_ff} + (FW+1)'(amt_ff);
               flow_in = fsum[FW] ? FLOW_MAX : fsum[FW-1:0];
               state_in = ST_SEARCH_INIT;
            end else begin
               state_in = ST_UPD_ADR;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_max_flow = flow_ff;

endmodule
